/* rtl/ipec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP protocol exception classifier package
// Shared widths, codes and types for the classifier front end and queue.
// ----------------------------------------------------------------------------
package ipec_pkg;

    localparam int LEN_W       = 16;
    localparam int PORT_W      = 16;
    localparam int TABLE_DEPTH = 65536;
    localparam int QUEUE_DEPTH = 2;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    // Protocol numbers
    localparam logic [7:0] PROTO_HOPOPT = 8'd0;
    localparam logic [7:0] PROTO_IPIP   = 8'd4;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_IPV6   = 8'd41;
    localparam logic [7:0] PROTO_ROUTE  = 8'd43;
    localparam logic [7:0] PROTO_FRAG   = 8'd44;
    localparam logic [7:0] PROTO_AH     = 8'd51;
    localparam logic [7:0] PROTO_ICMP6  = 8'd58;
    localparam logic [7:0] PROTO_DSTOPT = 8'd60;
    localparam logic [7:0] PROTO_OSPF   = 8'd89;
    localparam logic [7:0] PROTO_MOBIL  = 8'd135;
    localparam logic [7:0] PROTO_HIP    = 8'd139;
    localparam logic [7:0] PROTO_SHIM6  = 8'd140;

    localparam logic [7:0] ND_TYPE_LO = 8'd133;
    localparam logic [7:0] ND_TYPE_HI = 8'd137;
    localparam logic [3:0] IHL_MIN    = 4'd5;

    // Last-byte indices of fixed-size headers
    localparam logic [LEN_W-1:0] LAST_V4   = LEN_W'(19);
    localparam logic [LEN_W-1:0] LAST_V6   = LEN_W'(39);
    localparam logic [LEN_W-1:0] LAST_TCP  = LEN_W'(19);
    localparam logic [LEN_W-1:0] LAST_8B   = LEN_W'(7);

    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [1:0] {
        OP_BYTE     = 2'd0,
        OP_MARK_TCP = 2'd1,
        OP_MARK_UDP = 2'd2,
        OP_CLEAR    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_PORT    = 2'd1,
        CLS_OSPF    = 2'd2,
        CLS_ND      = 2'd3
    } pkt_class_t;

    typedef enum logic [8:0] {
        PH_START   = 9'b000000001,
        PH_V4      = 9'b000000010,
        PH_V6      = 9'b000000100,
        PH_EXT     = 9'b000001000,
        PH_EXTNEXT = 9'b000010000,
        PH_TCP     = 9'b000100000,
        PH_UDP     = 9'b001000000,
        PH_ICMP    = 9'b010000000,
        PH_DONE    = 9'b100000000
    } phase_t;

    // Result handed from the front end to the queue
    typedef struct packed {
        logic       valid;
        pkt_class_t cls;
    } result_t;

endpackage

/* rtl/ip_protocol_exception_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP protocol exception classifier
// Classifies IP packets streamed one byte per beat into OSPF, IPv6 neighbour
// discovery, marked TCP/UDP destination port, or unknown.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one beat per packet byte (byte opcode in tuser,
// the byte itself in tdata), or a mark-TCP-port, mark-UDP-port or
// clear-tables command in tuser.
// tlast marks the final byte of a packet; one class beat leaves on the
// master channel for each such byte, in order.
// Throughput is one beat per cycle while s_axis_tready is high; the header
// walker updates once per byte. A class is registered into a two-entry
// result queue as the last byte is accepted, then presented on the master channel from it.
// When the receiver stalls, the queue fills and s_axis_tready falls once two
// classes are waiting; packet bytes that give no class still pass meanwhile
// only while the queue has space.
// After reset, and after every clear-tables beat, the port tables are swept
// to zero at one entry per cycle, all 65536 entries, with s_axis_tready low.
// The match-enable register may be written at any time while idle.
// ----------------------------------------------------------------------------
module ip_protocol_exception_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // transport_match_enable
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // packet_byte, ether_type, port_number
    input  logic [1:0]  s_axis_tuser,   // opcode
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // packet_class, zero pad
);
    import ipec_pkg::*;

    result_t    res;
    logic       q_space;
    pkt_class_t out_cls;

    // Front end: parsing and port tables
    ipec_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (opcode_t'(s_axis_tuser)),
        .in_byte  (s_axis_tdata[7:0]),
        .in_last  (s_axis_tlast),
        .in_etype (s_axis_tdata[23:8]),
        .in_port  (s_axis_tdata[39:24]),
        .q_space  (q_space),
        .res      (res)
    );

    // Back end: result queue driving the master channel
    ipec_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .q_space  (q_space),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_cls  (out_cls)
    );

    assign m_axis_tdata = {6'b0, out_cls};

endmodule

/* rtl/ipec_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ipec_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ipec_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier front end
// Accepts beats, walks the IP header chain and owns the two port tables.
// ----------------------------------------------------------------------------
module ipec_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ipec_pkg::opcode_t     in_op,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  logic [15:0]           in_etype,
    input  logic [15:0]           in_port,
    input  logic                  q_space,
    output ipec_pkg::result_t     res
);
    import ipec_pkg::*;

    typedef struct packed {
        phase_t     ph;
        len_t       len;
        pkt_class_t cls;
    } disp_t;

    logic                enable_reg;
    phase_t              phase_reg, phase_next;
    len_t                cnt_reg, cnt_next;
    len_t                len_reg, len_next;
    logic [7:0]          np_reg, np_next;
    logic [PORT_W-1:0]   dp_reg, dp_next;
    pkt_class_t          cls_reg, cls_next;
    logic                pend_reg, pend_next;
    logic                hit_reg, hit_next;
    logic                clr_active_reg;
    logic [PORT_W-1:0]   clr_addr_reg;

    logic                acc, byte_acc, mark_tcp, mark_udp, clear_acc;
    logic                tcp_rd, udp_rd, hit_cur;
    logic                tcp_we, udp_we;
    logic [PORT_W-1:0]   waddr, raddr;

    phase_t              ph_e;
    len_t                i_e, len_e;
    pkt_class_t          cls_e;
    logic                at_end;
    disp_t               d;

    function automatic logic is_ext(input logic [7:0] p);
        return p == PROTO_HOPOPT || p == PROTO_ROUTE || p == PROTO_DSTOPT ||
               p == PROTO_MOBIL || p == PROTO_HIP || p == PROTO_SHIM6 ||
               p == PROTO_FRAG || p == PROTO_AH;
    endfunction

    // Choose the next header from a protocol number.
    function automatic disp_t dispatch(input logic [7:0] p, input logic allow_ext,
                                       input logic en);
        disp_t r;
        r = '{ph: PH_DONE, len: '0, cls: CLS_UNKNOWN};
        if (allow_ext && is_ext(p)) begin
            r.ph = PH_EXT; r.len = LAST_8B;
        end else if (p == PROTO_OSPF) begin
            r.cls = CLS_OSPF;
        end else if (p == PROTO_TCP) begin
            if (en) begin r.ph = PH_TCP; r.len = LAST_TCP; end
        end else if (p == PROTO_UDP) begin
            if (en) begin r.ph = PH_UDP; r.len = LAST_8B; end
        end else if (p == PROTO_IPIP) begin
            r.ph = PH_V4; r.len = LAST_V4;
        end else if (p == PROTO_IPV6) begin
            r.ph = PH_V6; r.len = LAST_V6;
        end else if (p == PROTO_ICMP6) begin
            r.ph = PH_ICMP; r.len = LAST_8B;
        end
        return r;
    endfunction

    // Handshake decode
    assign in_ready  = !clr_active_reg && q_space;
    assign acc       = in_valid && in_ready;
    assign byte_acc  = acc && (in_op == OP_BYTE);
    assign mark_tcp  = acc && (in_op == OP_MARK_TCP);
    assign mark_udp  = acc && (in_op == OP_MARK_UDP);
    assign clear_acc = acc && (in_op == OP_CLEAR);

    // Port tables: mark writes a one, the clearing pass writes zeros.
    assign waddr  = clr_active_reg ? clr_addr_reg : in_port;
    assign tcp_we = clr_active_reg || mark_tcp;
    assign udp_we = clr_active_reg || mark_udp;
    assign raddr  = {dp_reg[15:8], in_byte};

    ipec_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_tcp_table (
        .aclk(aclk), .we(tcp_we), .waddr(waddr), .wdata(!clr_active_reg),
        .raddr(raddr), .rdata(tcp_rd)
    );

    ipec_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_udp_table (
        .aclk(aclk), .we(udp_we), .waddr(waddr), .wdata(!clr_active_reg),
        .raddr(raddr), .rdata(udp_rd)
    );

    // Table hit for the current port, with marks and clears forwarded.
    always_comb begin
        hit_cur = pend_reg ? ((phase_reg == PH_TCP) ? tcp_rd : udp_rd) : hit_reg;
        hit_next = hit_cur;
        if (((mark_tcp && phase_reg == PH_TCP) || (mark_udp && phase_reg == PH_UDP)) &&
            in_port == dp_reg) begin
            hit_next = 1'b1;
        end
        if (clear_acc) begin
            hit_next = 1'b0;
        end
    end

    // Header walker: one packet byte per beat.
    always_comb begin
        ph_e   = phase_reg;
        i_e    = cnt_reg;
        len_e  = len_reg;
        cls_e  = cls_reg;
        d      = '{ph: PH_DONE, len: '0, cls: CLS_UNKNOWN};

        // First byte of a packet, or a header chosen after an extension header.
        if (phase_reg == PH_START) begin
            i_e = '0;
            if (in_etype == ETH_IPV4) begin
                ph_e = PH_V4; len_e = LAST_V4;
            end else if (in_etype == ETH_IPV6) begin
                ph_e = PH_V6; len_e = LAST_V6;
            end else begin
                ph_e = PH_DONE; cls_e = CLS_UNKNOWN;
            end
        end else if (phase_reg == PH_EXTNEXT) begin
            d     = dispatch(np_reg, 1'b1, enable_reg);
            ph_e  = d.ph;
            i_e   = '0;
            len_e = d.len;
            if (d.ph == PH_DONE) begin
                cls_e = d.cls;
            end
        end

        phase_next = ph_e;
        cnt_next   = i_e;
        len_next   = len_e;
        np_next    = np_reg;
        dp_next    = dp_reg;
        cls_next   = cls_e;
        pend_next  = 1'b0;
        at_end     = (i_e == len_e);

        unique case (ph_e)
            PH_V4: begin
                if (i_e == '0 && in_byte[3:0] < IHL_MIN) begin
                    phase_next = PH_DONE;
                    cls_next   = CLS_UNKNOWN;
                end else begin
                    if (i_e == '0) begin
                        len_next = LEN_W'({in_byte[3:0], 2'b00}) - LEN_W'(1);
                        at_end   = 1'b0;
                    end
                    if (i_e == LEN_W'(9)) begin
                        np_next = in_byte;
                    end
                    if (at_end) begin
                        d          = dispatch(np_next, 1'b0, enable_reg);
                        phase_next = d.ph;
                        cnt_next   = '0;
                        len_next   = d.len;
                        if (d.ph == PH_DONE) begin
                            cls_next = d.cls;
                        end
                    end else begin
                        cnt_next = i_e + LEN_W'(1);
                    end
                end
            end
            PH_V6: begin
                if (i_e == LEN_W'(6)) begin
                    np_next = in_byte;
                end
                if (at_end) begin
                    d          = dispatch(np_next, 1'b1, enable_reg);
                    phase_next = d.ph;
                    cnt_next   = '0;
                    len_next   = d.len;
                    if (d.ph == PH_DONE) begin
                        cls_next = d.cls;
                    end
                end else begin
                    cnt_next = i_e + LEN_W'(1);
                end
            end
            PH_EXT: begin
                if (i_e == '0) begin
                    dp_next = PORT_W'(in_byte);
                end
                if (i_e == LEN_W'(1)) begin
                    if (np_reg == PROTO_AH) begin
                        len_next = ((LEN_W'(in_byte) + LEN_W'(2)) << 2) - LEN_W'(1);
                    end else if (np_reg != PROTO_FRAG) begin
                        len_next = ((LEN_W'(in_byte) + LEN_W'(1)) << 3) - LEN_W'(1);
                    end
                    at_end = (i_e == len_next);
                end
                if (at_end) begin
                    np_next    = dp_next[7:0];
                    dp_next    = '0;
                    phase_next = PH_EXTNEXT;
                end else begin
                    cnt_next = i_e + LEN_W'(1);
                end
            end
            PH_TCP, PH_UDP: begin
                if (i_e == LEN_W'(2)) begin
                    dp_next = {in_byte, 8'h00};
                end
                if (i_e == LEN_W'(3)) begin
                    dp_next   = {dp_reg[15:8], in_byte};
                    pend_next = !in_last;
                end
                if (at_end) begin
                    phase_next = PH_DONE;
                    cls_next   = hit_cur ? CLS_PORT : CLS_UNKNOWN;
                end else begin
                    cnt_next = i_e + LEN_W'(1);
                end
            end
            PH_ICMP: begin
                if (i_e == '0) begin
                    dp_next = PORT_W'(in_byte);
                end
                if (at_end) begin
                    phase_next = PH_DONE;
                    cls_next   = (dp_next >= PORT_W'(ND_TYPE_LO) &&
                                  dp_next <= PORT_W'(ND_TYPE_HI)) ? CLS_ND : CLS_UNKNOWN;
                end else begin
                    cnt_next = i_e + LEN_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Result on the last byte of a packet
    assign res.valid = byte_acc && in_last;
    assign res.cls   = cls_next;

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            phase_reg  <= PH_START;
            cnt_reg    <= '0;
            len_reg    <= '0;
            np_reg     <= '0;
            dp_reg     <= '0;
            cls_reg    <= CLS_UNKNOWN;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
            pend_reg <= byte_acc && pend_next;
            hit_reg  <= hit_next;
            if (byte_acc) begin
                if (in_last) begin
                    phase_reg <= PH_START;
                    cnt_reg   <= '0;
                    len_reg   <= '0;
                    np_reg    <= '0;
                    dp_reg    <= '0;
                    cls_reg   <= CLS_UNKNOWN;
                end else begin
                    phase_reg <= phase_next;
                    cnt_reg   <= cnt_next;
                    len_reg   <= len_next;
                    np_reg    <= np_next;
                    dp_reg    <= dp_next;
                    cls_reg   <= cls_next;
                end
            end
        end
    end

    // Clearing pass over both tables after reset and after a clear beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + PORT_W'(1);
            if (clr_addr_reg == '1) begin
                clr_active_reg <= 1'b0;
            end
        end else if (clear_acc) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
    end

    // A pending table read only ever belongs to a transport header.
    a_pend_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (phase_reg == PH_TCP || phase_reg == PH_UDP))
        else $error("table read pending outside a transport header");

    // Reset always starts a clearing pass.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> clr_active_reg)
        else $error("no clearing pass after reset");

    // A clear beat is followed by a clearing pass.
    a_clear_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_acc |=> (clr_active_reg && clr_addr_reg == '0))
        else $error("clear beat did not start a clearing pass");

endmodule

/* rtl/ipec_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier result queue
// Short queue that decouples the front end from the result channel.
// ----------------------------------------------------------------------------
module ipec_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ipec_pkg::result_t     res,
    output logic                  q_space,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ipec_pkg::pkt_class_t  out_cls
);
    import ipec_pkg::*;

    pkt_class_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pop;

    assign q_space   = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cls   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (res.valid && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (!res.valid && pop) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (res.valid) begin
            mem_reg[wr_ptr_reg] <= res.cls;
        end
    end

    // Pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (res.valid) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // Never push into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> q_space)
        else $error("result pushed into a full queue");

    // Occupancy stays within the depth.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

    // A held result does not change while the receiver stalls.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_cls)))
        else $error("stalled result changed");

endmodule

/* tb/ip_protocol_exception_classifier_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP protocol exception classifier testbench
// Streams single-byte corner beats, mark and clear commands, and generated
// IPv4/IPv6 packets (options, extension chains, nesting, truncation) into the
// classifier under several idle and stall patterns. A class predictor kept in
// step with every accepted beat supplies the expected class of each generated packet.
// ----------------------------------------------------------------------------
module ip_protocol_exception_classifier_tb;
    import ipec_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int ITEM_TARGET    = 1150;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;     // packet_byte, ether_type, port_number
    logic [1:0]  s_axis_tuser;     // opcode
    logic        s_axis_tlast;     // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // packet_class, zero pad

    ip_protocol_exception_classifier u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Class predictor state
    // ------------------------------------------------------------------
    bit          match_en;
    phase_t      walk_phase;
    logic [15:0] hdr_idx;
    logic [15:0] hdr_last;
    logic [7:0]  cur_proto;
    logic [15:0] l4_port;
    pkt_class_t  held_class;
    bit          tcp_marked [TABLE_DEPTH];
    bit          udp_marked [TABLE_DEPTH];

    pkt_class_t  class_fifo [$];
    int          errors;
    int          beats_sent;
    int          classes_seen;
    int          packets_sent;
    int          clears_sent;

    function automatic void walk_clear();
        walk_phase = PH_START;
        hdr_idx    = '0;
        hdr_last   = '0;
        cur_proto  = '0;
        l4_port    = '0;
        held_class = CLS_UNKNOWN;
    endfunction

    function automatic void open_header(phase_t p, logic [15:0] last_idx);
        walk_phase = p;
        hdr_idx    = '0;
        hdr_last   = last_idx;
    endfunction

    function automatic void decide(pkt_class_t c);
        held_class = c;
        walk_phase = PH_DONE;
    endfunction

    function automatic bit is_ext_hdr(logic [7:0] p);
        return p == PROTO_HOPOPT || p == PROTO_ROUTE || p == PROTO_DSTOPT ||
               p == PROTO_MOBIL || p == PROTO_HIP || p == PROTO_SHIM6 ||
               p == PROTO_FRAG || p == PROTO_AH;
    endfunction

    // Move on to whatever the finished header names.
    function automatic void follow_proto(logic [7:0] p, bit ext_ok);
        cur_proto = p;
        if (ext_ok && is_ext_hdr(p)) begin
            open_header(PH_EXT, LAST_8B);
        end else begin
            case (p)
                PROTO_OSPF: decide(CLS_OSPF);
                PROTO_TCP:  if (match_en) open_header(PH_TCP, LAST_TCP);
                            else decide(CLS_UNKNOWN);
                PROTO_UDP:  if (match_en) open_header(PH_UDP, LAST_8B);
                            else decide(CLS_UNKNOWN);
                PROTO_IPIP:  open_header(PH_V4, LAST_V4);
                PROTO_IPV6:  open_header(PH_V6, LAST_V6);
                PROTO_ICMP6: open_header(PH_ICMP, LAST_8B);
                default:     decide(CLS_UNKNOWN);
            endcase
        end
    endfunction

    // Advance the header walk by one packet byte.
    function automatic void walk_byte(logic [7:0] b, logic [15:0] et);
        bit          again;
        bit          at_end;
        logic [15:0] i;
        again = 1'b1;
        while (again) begin
            again  = 1'b0;
            i      = hdr_idx;
            at_end = (i == hdr_last);
            case (walk_phase)
                PH_START: begin
                    if (et == ETH_IPV4) open_header(PH_V4, LAST_V4);
                    else if (et == ETH_IPV6) open_header(PH_V6, LAST_V6);
                    else begin
                        decide(CLS_UNKNOWN);
                        return;
                    end
                    again = 1'b1;
                end
                PH_EXTNEXT: begin
                    follow_proto(cur_proto, 1'b1);
                    if (walk_phase == PH_DONE) return;
                    again = 1'b1;
                end
                PH_V4: begin
                    if (i == 0) begin
                        if (b[3:0] < IHL_MIN) begin
                            decide(CLS_UNKNOWN);
                            return;
                        end
                        hdr_last = 16'(b[3:0]) * 16'd4 - 16'd1;
                        at_end   = 1'b0;
                    end
                    if (i == 9) cur_proto = b;
                    if (at_end) begin
                        follow_proto(cur_proto, 1'b0);
                        return;
                    end
                end
                PH_V6: begin
                    if (i == 6) cur_proto = b;
                    if (at_end) begin
                        follow_proto(cur_proto, 1'b1);
                        return;
                    end
                end
                PH_EXT: begin
                    if (i == 0) l4_port = 16'(b);
                    if (i == 1) begin
                        if (cur_proto == PROTO_AH)
                            hdr_last = (16'(b) + 16'd2) * 16'd4 - 16'd1;
                        else if (cur_proto != PROTO_FRAG)
                            hdr_last = (16'(b) + 16'd1) * 16'd8 - 16'd1;
                        at_end = (i == hdr_last);
                    end
                    if (at_end) begin
                        cur_proto  = l4_port[7:0];
                        l4_port    = '0;
                        walk_phase = PH_EXTNEXT;
                        return;
                    end
                end
                PH_TCP, PH_UDP: begin
                    if (i == 2) l4_port = {b, 8'h00};
                    if (i == 3) l4_port = l4_port | 16'(b);
                    if (at_end) begin
                        if (walk_phase == PH_TCP ? tcp_marked[l4_port] : udp_marked[l4_port])
                            decide(CLS_PORT);
                        else
                            decide(CLS_UNKNOWN);
                        return;
                    end
                end
                PH_ICMP: begin
                    if (i == 0) l4_port = 16'(b);
                    if (at_end) begin
                        if (l4_port >= 16'(ND_TYPE_LO) && l4_port <= 16'(ND_TYPE_HI))
                            decide(CLS_ND);
                        else
                            decide(CLS_UNKNOWN);
                        return;
                    end
                end
                default: return;
            endcase
            if (!again) hdr_idx = i + 16'd1;
        end
    endfunction

    // Apply one accepted beat; returns 1 when the beat yields a class.
    function automatic bit classify_beat(opcode_t op, logic [7:0] b, bit last,
                                         logic [15:0] et, logic [15:0] port,
                                         output pkt_class_t cls);
        cls = CLS_UNKNOWN;
        case (op)
            OP_MARK_TCP: tcp_marked[port] = 1'b1;
            OP_MARK_UDP: udp_marked[port] = 1'b1;
            OP_CLEAR: begin
                foreach (tcp_marked[k]) tcp_marked[k] = 1'b0;
                foreach (udp_marked[k]) udp_marked[k] = 1'b0;
            end
            default: begin
                walk_byte(b, et);
                if (last) begin
                    cls = held_class;
                    walk_clear();
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    int send_idle_pct;
    int recv_stall_pct;
    bit recv_hold;

    // Offer one beat, wait for acceptance, then record its expected class if it has one.
    task automatic send_beat(opcode_t op, logic [7:0] b, bit last, logic [15:0] et,
                             logic [15:0] port, bit fixed, pkt_class_t fixed_cls);
        pkt_class_t cls;
        int         gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {port, et, b};
        do @(posedge aclk); while (!s_axis_tready);
        beats_sent++;
        if (op == OP_CLEAR) clears_sent++;
        if (classify_beat(op, b, last, et, port, cls))
            class_fifo.push_back(fixed ? fixed_cls : cls);
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Write the match-enable register once all classes are back.
    task automatic set_match_enable(bit v);
        s_axis_tvalid <= 1'b0;
        wait (class_fifo.size() == 0);
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        match_en  = v;
    endtask

    // ------------------------------------------------------------------
    // Packet generation
    // ------------------------------------------------------------------
    logic [7:0]  pkt_bytes [$];
    logic [15:0] port_pool [8];
    logic [7:0]  ext_kinds [8] = '{PROTO_HOPOPT, PROTO_ROUTE, PROTO_DSTOPT, PROTO_MOBIL,
                                   PROTO_HIP, PROTO_SHIM6, PROTO_FRAG, PROTO_AH};

    function automatic logic [7:0] pick_upper(int depth);
        int r;
        r = $urandom_range(depth >= 2 ? 4 : 6);
        case (r)
            0: return PROTO_OSPF;
            1: return PROTO_TCP;
            2: return PROTO_UDP;
            3: return PROTO_ICMP6;
            4: return 8'($urandom);
            5: return PROTO_IPIP;
            default: return PROTO_IPV6;
        endcase
    endfunction

    function automatic void push_random(int n);
        repeat (n) pkt_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_upper(logic [7:0] p, int depth);
        logic [15:0] prt;
        int          base;
        base = pkt_bytes.size();
        prt  = ($urandom_range(3) != 0) ? port_pool[$urandom_range(7)] : 16'($urandom);
        case (p)
            PROTO_TCP, PROTO_UDP: begin
                push_random(p == PROTO_TCP ? 20 : 8);
                pkt_bytes[base + 2] = prt[15:8];
                pkt_bytes[base + 3] = prt[7:0];
            end
            PROTO_ICMP6: begin
                push_random(8);
                pkt_bytes[base] = ($urandom_range(2) != 0) ?
                                  8'($urandom_range(ND_TYPE_LO - 1, ND_TYPE_HI + 1)) :
                                  8'($urandom);
            end
            PROTO_IPIP: add_ip(1'b0, depth + 1);
            PROTO_IPV6: add_ip(1'b1, depth + 1);
            default: ;
        endcase
    endfunction

    function automatic void add_ip(bit v6, int depth);
        logic [7:0] upper;
        logic [7:0] chain [$];
        logic [3:0] ihl;
        int         base;
        int         n;
        int         len;
        upper = pick_upper(depth);
        base  = pkt_bytes.size();
        if (!v6) begin
            ihl = 4'd5;
            if ($urandom_range(99) < 10) ihl = 4'($urandom_range(6, 15));
            else if ($urandom_range(99) < 5) ihl = 4'($urandom_range(0, 4));
            push_random(ihl < IHL_MIN ? 20 : int'(ihl) * 4);
            pkt_bytes[base]     = {4'h4, ihl};
            pkt_bytes[base + 9] = ($urandom_range(9) == 0) ?
                                  ext_kinds[$urandom_range(7)] : upper;
            add_upper(pkt_bytes[base + 9], depth);
        end else begin
            if ($urandom_range(99) < 45)
                repeat ($urandom_range(1, 3)) chain.push_back(ext_kinds[$urandom_range(7)]);
            chain.push_back(upper);
            push_random(40);
            pkt_bytes[base]     = 8'h60;
            pkt_bytes[base + 6] = chain[0];
            // Extension header chain, each naming the next.
            for (int k = 0; k + 1 < chain.size(); k++) begin
                base = pkt_bytes.size();
                if (chain[k] == PROTO_FRAG) begin
                    n = $urandom_range(255);
                    len = 8;
                end else if (chain[k] == PROTO_AH) begin
                    n = $urandom_range(3);
                    len = (n + 2) * 4;
                end else begin
                    n = $urandom_range(2);
                    len = (n + 1) * 8;
                end
                push_random(len);
                pkt_bytes[base]     = chain[k + 1];
                pkt_bytes[base + 1] = 8'(n);
            end
            add_upper(upper, depth);
        end
    endfunction

    // Build and stream one packet, with stray commands between its bytes.
    task automatic send_packet();
        logic [15:0] et;
        int          r;
        int          cut;
        pkt_bytes.delete();
        r = $urandom_range(99);
        if (r < 8) begin
            et = 16'($urandom);
            push_random($urandom_range(1, 6));
        end else begin
            et = (r < 60) ? ETH_IPV4 : ETH_IPV6;
            add_ip(et == ETH_IPV6, 0);
            push_random($urandom_range(0, 6));
            if ($urandom_range(99) < 10) begin
                cut = $urandom_range(1, pkt_bytes.size());
                while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
            end
        end
        foreach (pkt_bytes[k]) begin
            if ($urandom_range(99) < 2)
                send_beat(opcode_t'($urandom_range(1, 2)), 8'($urandom), 1'($urandom),
                          16'($urandom), port_pool[$urandom_range(7)], 1'b0, CLS_UNKNOWN);
            send_beat(OP_BYTE, pkt_bytes[k], k == pkt_bytes.size() - 1,
                      k == 0 ? et : 16'($urandom), 16'($urandom), 1'b0, CLS_UNKNOWN);
        end
        packets_sent++;
    endtask

    // ------------------------------------------------------------------
    // Directed corner beats
    // ------------------------------------------------------------------
    typedef struct {
        opcode_t     op;
        logic [7:0]  b;
        bit          last;
        logic [15:0] et;
        logic [15:0] port;
        bit          fixed;
        pkt_class_t  cls;
    } corner_row_t;

    corner_row_t corner_rows [$];

    initial begin
        // Unknown ether types, including all ones.
        corner_rows.push_back('{OP_BYTE, 8'h00, 1, 16'h0000, 16'h0000, 1, CLS_UNKNOWN});
        corner_rows.push_back('{OP_BYTE, 8'hFF, 1, 16'hFFFF, 16'hFFFF, 1, CLS_UNKNOWN});
        // IHL below five, and packets ending inside the IP header.
        corner_rows.push_back('{OP_BYTE, 8'h44, 1, ETH_IPV4, 16'h0000, 1, CLS_UNKNOWN});
        corner_rows.push_back('{OP_BYTE, 8'h45, 1, ETH_IPV4, 16'h0000, 1, CLS_UNKNOWN});
        corner_rows.push_back('{OP_BYTE, 8'h60, 1, ETH_IPV6, 16'hFFFF, 1, CLS_UNKNOWN});
        corner_rows.push_back('{OP_BYTE, 8'h40, 0, ETH_IPV4, 16'h1234, 1, CLS_UNKNOWN});
        corner_rows.push_back('{OP_BYTE, 8'hAA, 1, 16'hFFFF, 16'h0000, 1, CLS_UNKNOWN});
        // Marks at the port extremes, some with a stray last flag, then a clear and one more mark.
        corner_rows.push_back('{OP_MARK_TCP, 8'hFF, 1, 16'hFFFF, 16'h0000, 0, CLS_UNKNOWN});
        corner_rows.push_back('{OP_MARK_TCP, 8'h00, 0, 16'h0000, 16'hFFFF, 0, CLS_UNKNOWN});
        corner_rows.push_back('{OP_MARK_UDP, 8'h00, 0, 16'h0000, 16'h0000, 0, CLS_UNKNOWN});
        corner_rows.push_back('{OP_MARK_UDP, 8'h00, 1, 16'h0000, 16'hFFFF, 0, CLS_UNKNOWN});
        corner_rows.push_back('{OP_CLEAR, 8'hFF, 1, 16'hFFFF, 16'hFFFF, 0, CLS_UNKNOWN});
        corner_rows.push_back('{OP_MARK_TCP, 8'h00, 0, 16'h0000, 16'h0050, 0, CLS_UNKNOWN});
    end

    // ------------------------------------------------------------------
    // Receiver and result checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_axis_tready <= recv_hold ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            classes_seen++;
            if (class_fifo.size() == 0) begin
                errors++;
                $display("%0t: unexpected class beat, expected none, actual %0d",
                         $realtime, m_axis_tdata);
            end else if (m_axis_tdata != {6'b0, class_fifo[0]}) begin
                errors++;
                $display("%0t: class mismatch, expected %0d, actual %0d",
                         $realtime, class_fifo[0], m_axis_tdata);
                void'(class_fifo.pop_front());
            end else begin
                void'(class_fifo.pop_front());
            end
        end
    end

    // Watchdog on cycles with no beat moving on either channel.
    int quiet_cycles;
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    int idle_modes  [4] = '{0, 81, 0, 33};
    int stall_modes [4] = '{0, 0, 81, 33};
    bit enable_mode [4] = '{1, 0, 1, 1};

    initial begin
        int pkts_at_start;
        aresetn        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= OP_BYTE;
        s_axis_tlast   <= 1'b0;
        m_axis_tready  <= 1'b0;
        recv_hold      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        errors         = 0;
        beats_sent     = 0;
        classes_seen   = 0;
        packets_sent   = 0;
        clears_sent    = 0;
        quiet_cycles   = 0;
        match_en       = 1'b0;
        walk_clear();
        port_pool = '{16'h0000, 16'hFFFF, 16'h0050, 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom)};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats, then four generated packets with match enable still off.
        foreach (corner_rows[k])
            send_beat(corner_rows[k].op, corner_rows[k].b, corner_rows[k].last,
                      corner_rows[k].et, corner_rows[k].port, corner_rows[k].fixed,
                      corner_rows[k].cls);
        repeat (4) send_packet();

        // Random phases over the idle and stall patterns.
        for (int m = 0; m < 4; m++) begin
            set_match_enable(enable_mode[m]);
            send_idle_pct  = idle_modes[m];
            recv_stall_pct = stall_modes[m];
            if (m == 0) begin
                // Long receiver hold-off so the result queue fills and back-pressures.
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (400) @(posedge aclk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            pkts_at_start = packets_sent;
            while (beats_sent < ITEM_TARGET * (m + 1) / 4 ||
                   packets_sent - pkts_at_start < 4) begin
                if (packets_sent % 20 == 7) begin
                    // Short run-time burst with no idling at all.
                    send_idle_pct = 0;
                    send_packet();
                    send_idle_pct = idle_modes[m];
                end else begin
                    send_packet();
                end
                if (clears_sent < 4 && $urandom_range(99) < 1)
                    send_beat(OP_CLEAR, 8'($urandom), 1'b0, 16'($urandom),
                              16'($urandom), 1'b0, CLS_UNKNOWN);
            end
        end
        set_match_enable(1'b0);
        s_axis_tvalid <= 1'b0;

        wait (class_fifo.size() == 0);
        repeat (20) @(posedge aclk);
        $display("Covered %0d input beats in %0d packets, %0d table clears, %0d classes",
                 beats_sent, packets_sent, clears_sent, classes_seen);
        $display("Idle/stall patterns: none, sender, receiver, both; enable 0 and 1");
        if (errors == 0 && class_fifo.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* ip_protocol_exception_classifier.f */
rtl/ipec_pkg.sv
rtl/ipec_ram.sv
rtl/ipec_front.sv
rtl/ipec_queue.sv
rtl/ip_protocol_exception_classifier.sv
tb/ip_protocol_exception_classifier_tb.sv
